// ===== rtl/delay_injecting_release_queue_defines.svh =====
// assertion macros for the delay injecting release queue
// expects clk and arst_n in the scope of the module that uses them
`ifndef DELAY_INJECTING_RELEASE_QUEUE_DEFINES_SVH
`define DELAY_INJECTING_RELEASE_QUEUE_DEFINES_SVH

// same-cycle implication, ignored while in reset
`define DIRQ_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, ignored while in reset
`define DIRQ_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/dirq_pkg.sv =====
// shared types, codes and defaults for the delay injecting release queue
// no dependencies
package dirq_pkg;

	localparam int unsigned QUEUE_DEPTH_DEF = 64;
	localparam int unsigned TAG_BITS_DEF    = 16;
	localparam int unsigned FIFO_DEPTH      = 4;
	localparam int unsigned TIME_W          = 64;
	localparam int unsigned RAND_W          = 32;
	localparam int unsigned CFG_W           = 40;
	localparam int unsigned CFG_IDX_W       = 3;

	localparam logic CMD_INSERT   = 1'b0;
	localparam logic CMD_DISPATCH = 1'b1;

	localparam logic [2:0] STAT_INSERTED   = 3'd0;
	localparam logic [2:0] STAT_FULL       = 3'd1;
	localparam logic [2:0] STAT_DISPATCHED = 3'd2;
	localparam logic [2:0] STAT_NOT_DUE    = 3'd3;
	localparam logic [2:0] STAT_EMPTY      = 3'd4;

	localparam logic [CFG_IDX_W-1:0] CFG_RULE_ENABLE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_OP_FILTER   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MEAN_DELAY  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_JITTER      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_CORR_RHO    = 3'd4;

	localparam logic [1:0] FILT_READ  = 2'd1;
	localparam logic [1:0] FILT_WRITE = 2'd2;

	typedef struct packed {
		logic        cmd;
		logic [63:0] now_ns;
		logic [15:0] req_tag;
		logic        is_read;
		logic        is_write;
		logic        has_data;
		logic        at_head;
		logic [31:0] random_word;
	} req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [15:0] out_tag;
		logic [63:0] release_time;
		logic [6:0]  queue_count;
	} rsp_t;

	typedef struct packed {
		logic idle;
		logic full;
	} back_stat_t;

endpackage

// ===== rtl/dirq_ram.sv =====
// generic single write port ram with registered read
// no dependencies
module dirq_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/dirq_fifo.sv =====
// short flop queue between the front and back parts
// no dependencies
module dirq_fifo #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  logic [WIDTH-1:0] push_data,
	output logic             pop_valid,
	input  logic             pop_ready,
	output logic [WIDTH-1:0] pop_data
);

	localparam int unsigned AW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    cnt_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = cnt_q != CW'(DEPTH);
	assign pop_valid  = cnt_q != '0;
	assign pop_data   = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/dirq_front.sv =====
// front part: config registers, intake, rule match and release time computation
// depends on dirq_pkg
module dirq_front #(
	parameter int unsigned TAG_BITS = dirq_pkg::TAG_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [dirq_pkg::CFG_IDX_W-1:0]      cfg_idx,
	input  logic [dirq_pkg::CFG_W-1:0]          cfg_wdata,
	input  logic                                req_valid,
	output logic                                req_ready,
	input  dirq_pkg::req_t                      req,
	output logic                                push_valid,
	input  logic                                push_ready,
	output logic [dirq_pkg::TIME_W+TAG_BITS:0]  push_data,
	input  logic                                fifo_empty,
	input  dirq_pkg::back_stat_t                bstat
);

	localparam logic [3:0] F_IDLE  = 4'd0;
	localparam logic [3:0] F_CLASS = 4'd1;
	localparam logic [3:0] F_WAIT  = 4'd2;
	localparam logic [3:0] F_MUL1  = 4'd3;
	localparam logic [3:0] F_MUL2  = 4'd4;
	localparam logic [3:0] F_SUM   = 4'd5;
	localparam logic [3:0] F_DIV   = 4'd6;
	localparam logic [3:0] F_OFF   = 4'd7;
	localparam logic [3:0] F_ADD   = 4'd8;
	localparam logic [3:0] F_PUSH  = 4'd9;

	logic [3:0]            state_q;
	dirq_pkg::req_t        item_q;
	logic [63:0]           time_q;
	logic [31:0]           last_q;
	logic [63:0]           p1_q;
	logic [63:0]           p2_q;
	logic [31:0]           r_q;
	logic [31:0]           rem_q;
	logic [4:0]            div_cnt_q;
	logic [63:0]           off_q;
	logic                  rule_en_q;
	logic [1:0]            op_filter_q;
	logic [39:0]           mean_q;
	logic [30:0]           jitter_q;
	logic [31:0]           rho_q;

	logic                  match;
	logic [63:0]           base;
	logic [31:0]           span;
	logic [31:0]           mul_a;
	logic [31:0]           mul_b;
	logic [63:0]           prod;
	logic [65:0]           sum66;
	logic [31:0]           r_new;
	logic [32:0]           rem_sh;
	logic [32:0]           rem_diff;
	logic                  rem_ge;
	logic [31:0]           rem_nx;
	logic [31:0]           tag_ext;

	assign match = rule_en_q && item_q.has_data
		&& !(op_filter_q == dirq_pkg::FILT_READ && !item_q.is_read)
		&& !(op_filter_q == dirq_pkg::FILT_WRITE && !item_q.is_write);
	assign base  = item_q.at_head ? '0 : item_q.now_ns;
	assign span  = {jitter_q, 1'b0};

	// one shared multiplier for both correlation products
	assign mul_a = (state_q == F_MUL1) ? item_q.random_word : last_q;
	assign mul_b = (state_q == F_MUL1) ? ~rho_q : rho_q;
	assign prod  = mul_a * mul_b;
	assign sum66 = {2'b00, p1_q} + {2'b00, p2_q} + {34'd0, last_q};
	assign r_new = sum66[63:32];

	// restoring remainder, one bit a cycle
	assign rem_sh   = {rem_q, r_q[31]};
	assign rem_ge   = rem_sh >= {1'b0, span};
	assign rem_diff = rem_sh - {1'b0, span};
	assign rem_nx   = rem_ge ? rem_diff[31:0] : rem_sh[31:0];

	assign tag_ext    = {16'd0, item_q.req_tag};
	assign push_data  = {item_q.cmd, time_q, tag_ext[TAG_BITS-1:0]};
	assign push_valid = state_q == F_PUSH;
	assign req_ready  = state_q == F_IDLE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rule_en_q   <= 1'b0;
			op_filter_q <= '0;
			mean_q      <= '0;
			jitter_q    <= '0;
			rho_q       <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				dirq_pkg::CFG_RULE_ENABLE: rule_en_q   <= cfg_wdata[0];
				dirq_pkg::CFG_OP_FILTER:   op_filter_q <= cfg_wdata[1:0];
				dirq_pkg::CFG_MEAN_DELAY:  mean_q      <= cfg_wdata[39:0];
				dirq_pkg::CFG_JITTER:      jitter_q    <= cfg_wdata[30:0];
				dirq_pkg::CFG_CORR_RHO:    rho_q       <= cfg_wdata[31:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= F_IDLE;
			last_q    <= '0;
			div_cnt_q <= '0;
		end else begin
			unique case (state_q)
				F_IDLE: begin
					if (req_valid) begin
						state_q <= F_CLASS;
					end
				end
				F_CLASS: begin
					if (item_q.cmd == dirq_pkg::CMD_DISPATCH || !match || jitter_q == '0) begin
						state_q <= F_PUSH;
					end else begin
						state_q <= F_WAIT;
					end
				end
				F_WAIT: begin
					// draw only once the back part has settled the count
					if (fifo_empty && bstat.idle) begin
						div_cnt_q <= '0;
						if (bstat.full) begin
							state_q <= F_PUSH;
						end else if (rho_q == '0) begin
							state_q <= F_DIV;
						end else begin
							state_q <= F_MUL1;
						end
					end
				end
				F_MUL1: state_q <= F_MUL2;
				F_MUL2: state_q <= F_SUM;
				F_SUM: begin
					last_q    <= r_new;
					div_cnt_q <= '0;
					state_q   <= F_DIV;
				end
				F_DIV: begin
					div_cnt_q <= div_cnt_q + 1'b1;
					if (div_cnt_q == 5'(dirq_pkg::RAND_W - 1)) begin
						state_q <= F_OFF;
					end
				end
				F_OFF: state_q <= F_ADD;
				F_ADD: state_q <= F_PUSH;
				F_PUSH: begin
					if (push_ready) begin
						state_q <= F_IDLE;
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			F_IDLE: begin
				if (req_valid) begin
					item_q <= req;
				end
			end
			F_CLASS: begin
				if (item_q.cmd == dirq_pkg::CMD_DISPATCH) begin
					time_q <= item_q.now_ns;
				end else if (match && jitter_q == '0) begin
					time_q <= base + {24'd0, mean_q};
				end else begin
					time_q <= base;
				end
			end
			F_WAIT: begin
				r_q   <= item_q.random_word;
				rem_q <= '0;
			end
			F_MUL1: p1_q <= prod;
			F_MUL2: p2_q <= prod;
			F_SUM:  r_q  <= r_new;
			F_DIV: begin
				rem_q <= rem_nx;
				r_q   <= {r_q[30:0], 1'b0};
			end
			F_OFF: off_q  <= {24'd0, mean_q} + {32'd0, rem_q} - {33'd0, jitter_q};
			F_ADD: time_q <= time_q + off_q;
			default: ;
		endcase
	end

endmodule

// ===== rtl/dirq_back.sv =====
// back part: sorted ring of entries in ram, insert and dispatch, output register
// depends on dirq_pkg, dirq_ram and the assertion macro header
`include "delay_injecting_release_queue_defines.svh"

module dirq_back #(
	parameter int unsigned QUEUE_DEPTH = dirq_pkg::QUEUE_DEPTH_DEF,
	parameter int unsigned TAG_BITS    = dirq_pkg::TAG_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               pop_valid,
	output logic                               pop_ready,
	input  logic [dirq_pkg::TIME_W+TAG_BITS:0] pop_data,
	output dirq_pkg::back_stat_t               bstat,
	output logic                               rsp_valid,
	input  logic                               rsp_ready,
	output dirq_pkg::rsp_t                     rsp
);

	localparam int unsigned IDX_W = $clog2(QUEUE_DEPTH);
	localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int unsigned MEM_W = dirq_pkg::TIME_W + TAG_BITS;

	localparam logic [2:0] ST_IDLE    = 3'd0;
	localparam logic [2:0] ST_INS_RD  = 3'd1;
	localparam logic [2:0] ST_INS_CMP = 3'd2;
	localparam logic [2:0] ST_DSP_CMP = 3'd3;
	localparam logic [2:0] ST_RESULT  = 3'd4;

	function automatic logic [IDX_W-1:0] phys(input logic [IDX_W-1:0] head,
			input logic [CNT_W-1:0] off);
		logic [CNT_W:0] s;
		s = (CNT_W+1)'(head) + (CNT_W+1)'(off);
		if (s >= (CNT_W+1)'(QUEUE_DEPTH)) begin
			s = s - (CNT_W+1)'(QUEUE_DEPTH);
		end
		return s[IDX_W-1:0];
	endfunction

	logic [2:0]          state_q;
	logic [IDX_W-1:0]    head_q;
	logic [CNT_W-1:0]    count_q;
	logic [CNT_W-1:0]    pos_q;
	logic                rsp_valid_q;
	logic [63:0]         op_time_q;
	logic [TAG_BITS-1:0] op_tag_q;
	logic [2:0]          res_status_q;
	logic [TAG_BITS-1:0] res_tag_q;
	logic [63:0]         res_time_q;
	dirq_pkg::rsp_t      rsp_q;

	logic                pop_cmd;
	logic [63:0]         pop_time;
	logic [TAG_BITS-1:0] pop_tag;
	logic                ram_we;
	logic [IDX_W-1:0]    ram_waddr;
	logic [MEM_W-1:0]    ram_wdata;
	logic [IDX_W-1:0]    ram_raddr;
	logic [MEM_W-1:0]    ram_rdata;
	logic [63:0]         rd_time;
	logic [TAG_BITS-1:0] rd_tag;
	logic                shift_hit;
	logic                full;
	logic                can_load;
	logic [31:0]         tag_ext;
	logic [15:0]         cnt_ext;

	assign pop_cmd   = pop_data[dirq_pkg::TIME_W+TAG_BITS];
	assign pop_time  = pop_data[MEM_W-1 -: 64];
	assign pop_tag   = pop_data[TAG_BITS-1:0];
	assign rd_time   = ram_rdata[MEM_W-1 -: 64];
	assign rd_tag    = ram_rdata[TAG_BITS-1:0];
	assign shift_hit = rd_time >= op_time_q;
	assign full      = count_q == CNT_W'(QUEUE_DEPTH);
	assign can_load  = !rsp_valid_q || rsp_ready;
	assign pop_ready = state_q == ST_IDLE;
	assign bstat     = '{idle: state_q == ST_IDLE, full: full};
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign tag_ext   = 32'(res_tag_q);
	assign cnt_ext   = 16'(count_q);

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = phys(head_q, pos_q);
		ram_wdata = {op_time_q, op_tag_q};
		ram_raddr = phys(head_q, '0);
		unique case (state_q)
			ST_INS_RD: begin
				if (pos_q == '0) begin
					ram_we = 1'b1;
				end else begin
					ram_raddr = phys(head_q, pos_q - 1'b1);
				end
			end
			ST_INS_CMP: begin
				ram_we = 1'b1;
				if (shift_hit) begin
					ram_wdata = ram_rdata;
				end
			end
			default: ;
		endcase
	end

	dirq_ram #(
		.WIDTH (MEM_W),
		.DEPTH (QUEUE_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			head_q      <= '0;
			count_q     <= '0;
			pos_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_RESULT && can_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (pop_valid) begin
						if (pop_cmd == dirq_pkg::CMD_INSERT) begin
							if (full) begin
								state_q <= ST_RESULT;
							end else begin
								pos_q   <= count_q;
								state_q <= ST_INS_RD;
							end
						end else if (count_q == '0) begin
							state_q <= ST_RESULT;
						end else begin
							state_q <= ST_DSP_CMP;
						end
					end
				end
				ST_INS_RD: begin
					if (pos_q == '0) begin
						count_q <= count_q + 1'b1;
						state_q <= ST_RESULT;
					end else begin
						state_q <= ST_INS_CMP;
					end
				end
				ST_INS_CMP: begin
					if (shift_hit) begin
						pos_q   <= pos_q - 1'b1;
						state_q <= ST_INS_RD;
					end else begin
						count_q <= count_q + 1'b1;
						state_q <= ST_RESULT;
					end
				end
				ST_DSP_CMP: begin
					if (!(rd_time > op_time_q)) begin
						head_q  <= phys(head_q, CNT_W'(1));
						count_q <= count_q - 1'b1;
					end
					state_q <= ST_RESULT;
				end
				ST_RESULT: begin
					if (can_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				op_time_q    <= pop_time;
				op_tag_q     <= pop_tag;
				res_tag_q    <= '0;
				res_time_q   <= '0;
				res_status_q <= (pop_cmd == dirq_pkg::CMD_INSERT) ?
					dirq_pkg::STAT_FULL : dirq_pkg::STAT_EMPTY;
			end
			ST_INS_RD, ST_INS_CMP: begin
				res_status_q <= dirq_pkg::STAT_INSERTED;
				res_tag_q    <= '0;
				res_time_q   <= op_time_q;
			end
			ST_DSP_CMP: begin
				res_time_q <= rd_time;
				if (rd_time > op_time_q) begin
					res_status_q <= dirq_pkg::STAT_NOT_DUE;
					res_tag_q    <= '0;
				end else begin
					res_status_q <= dirq_pkg::STAT_DISPATCHED;
					res_tag_q    <= rd_tag;
				end
			end
			ST_RESULT: begin
				if (can_load) begin
					rsp_q.status       <= res_status_q;
					rsp_q.out_tag      <= tag_ext[15:0];
					rsp_q.release_time <= res_time_q;
					rsp_q.queue_count  <= cnt_ext[6:0];
				end
			end
			default: ;
		endcase
	end

	`DIRQ_ASSERT_IMPL(a_count_bound, 1'b1, count_q <= CNT_W'(QUEUE_DEPTH), "count past depth")
	`DIRQ_ASSERT_IMPL(a_dsp_nonempty, state_q == ST_DSP_CMP, count_q != '0, "dispatch on empty")
	`DIRQ_ASSERT_IMPL(a_ins_pos, state_q == ST_INS_RD || state_q == ST_INS_CMP, pos_q <= count_q && !full, "insert position out of range")
	`DIRQ_ASSERT_NEXT(a_rsp_load, state_q == ST_RESULT && can_load, rsp_valid_q, "result not presented")

endmodule

// ===== rtl/delay_injecting_release_queue.sv =====
// top level of the delay injecting release queue
// depends on dirq_pkg, dirq_front, dirq_fifo and dirq_back
//
// Requests are held in a ring memory sorted by release time, newest first
// among equal times; the memory needs no clearing pass after reset. An item
// is taken in, classified in the front part and handed through a four-entry
// queue to the back part, which owns the memory and the output register. A
// dispatch compares the head entry and passes its result through the result
// state to the output register. An insert reads and compares the held
// entries from the tail, shifting up each one whose time is at or after the
// new one, as the back part walks the ring one entry per memory read. A
// jittered insert first waits for the back part to drain, then forms the
// correlation products (one shared 32x32 multiplier, skipped when corr_rho is
// zero), the remainder one bit at a time, then the offset and the final sum.
module delay_injecting_release_queue #(
	parameter int unsigned QUEUE_DEPTH = dirq_pkg::QUEUE_DEPTH_DEF,
	parameter int unsigned TAG_BITS    = dirq_pkg::TAG_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [dirq_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [dirq_pkg::CFG_W-1:0]     cfg_wdata,
	input  logic                           req_valid,
	output logic                           req_ready,
	input  dirq_pkg::req_t                 req,
	output logic                           rsp_valid,
	input  logic                           rsp_ready,
	output dirq_pkg::rsp_t                 rsp
);

	localparam int unsigned ENTRY_W = dirq_pkg::TIME_W + TAG_BITS + 1;

	logic                 push_valid;
	logic                 push_ready;
	logic [ENTRY_W-1:0]   push_data;
	logic                 pop_valid;
	logic                 pop_ready;
	logic [ENTRY_W-1:0]   pop_data;
	dirq_pkg::back_stat_t bstat;

	dirq_front #(
		.TAG_BITS (TAG_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_idx    (cfg_idx),
		.cfg_wdata  (cfg_wdata),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.req        (req),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.fifo_empty (!pop_valid),
		.bstat      (bstat)
	);

	dirq_fifo #(
		.WIDTH (ENTRY_W),
		.DEPTH (dirq_pkg::FIFO_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	dirq_back #(
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.TAG_BITS    (TAG_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data),
		.bstat     (bstat),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule

// ===== bench/tb_delay_injecting_release_queue.sv =====
// self-checking bench for the delay injecting release queue: directed and random
// transfers with idling and back-pressure, each response checked against a predictor
// depends on dirq_pkg and delay_injecting_release_queue
`timescale 1ns / 1ps

module tb_delay_injecting_release_queue;

	localparam int QDEPTH = dirq_pkg::QUEUE_DEPTH_DEF;
	localparam int LIMIT  = 1000000;

	logic                           clk;
	logic                           arst_n;
	logic                           cfg_we;
	logic [dirq_pkg::CFG_IDX_W-1:0] cfg_idx;
	logic [dirq_pkg::CFG_W-1:0]     cfg_wdata;
	logic                           req_valid;
	logic                           req_ready;
	dirq_pkg::req_t                 req;
	logic                           rsp_valid;
	logic                           rsp_ready;
	dirq_pkg::rsp_t                 rsp;

	// predictor state
	logic [63:0] held_time [QDEPTH];
	logic [15:0] held_tag [QDEPTH];
	int          held;
	logic [31:0] rand_hist;
	logic        cfg_en;
	logic [1:0]  cfg_filt;
	logic [39:0] cfg_mean;
	logic [30:0] cfg_jit;
	logic [31:0] cfg_rho;

	dirq_pkg::rsp_t pending_rsp [$];
	int             mismatches;
	int             cycles;
	int             send_idle;
	int             recv_idle;
	logic [63:0]    sim_now;
	bit             stall_kick;
	bit             stall_seen;
	int             stall_left;

	delay_injecting_release_queue i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// receiver with random idling and long hold-off on request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ready  <= 1'b0;
			stall_left <= 0;
			stall_seen <= 1'b0;
		end else if (stall_kick != stall_seen) begin
			stall_seen <= stall_kick;
			stall_left <= 400;
			rsp_ready  <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			rsp_ready  <= 1'b0;
		end else begin
			rsp_ready <= ($urandom_range(99) >= recv_idle);
		end
	end

	function automatic dirq_pkg::rsp_t release_predict(dirq_pkg::req_t it);
		dirq_pkg::rsp_t o;
		logic [63:0]    t;
		logic [31:0]    r;
		logic [31:0]    span;
		logic [32:0]    p;
		logic [64:0]    acc;
		int             pos;
		o = '0;
		if (it.cmd == dirq_pkg::CMD_INSERT) begin
			if (held >= QDEPTH) begin
				o.status = dirq_pkg::STAT_FULL;
			end else begin
				t = it.at_head ? 64'd0 : it.now_ns;
				if (cfg_en && it.has_data && !(cfg_filt == dirq_pkg::FILT_READ && !it.is_read)
						&& !(cfg_filt == dirq_pkg::FILT_WRITE && !it.is_write)) begin
					if (cfg_jit == 0) begin
						t = t + {24'd0, cfg_mean};
					end else begin
						if (cfg_rho == 0) begin
							r = it.random_word;
						end else begin
							p = {1'b0, cfg_rho} + 33'd1;
							acc = {33'd0, it.random_word} * (65'h1_0000_0000 - {32'd0, p})
								+ {33'd0, rand_hist} * {32'd0, p};
							r = acc[63:32];
							rand_hist = r;
						end
						span = {cfg_jit, 1'b0};
						t = t + {32'd0, r % span} + {24'd0, cfg_mean} - {33'd0, cfg_jit};
					end
				end
				pos = 0;
				while (pos < held && held_time[pos] < t)
					pos++;
				for (int i = held; i > pos; i--) begin
					held_time[i] = held_time[i-1];
					held_tag[i]  = held_tag[i-1];
				end
				held_time[pos] = t;
				held_tag[pos]  = it.req_tag;
				held++;
				o.status       = dirq_pkg::STAT_INSERTED;
				o.release_time = t;
			end
		end else if (held == 0) begin
			o.status = dirq_pkg::STAT_EMPTY;
		end else if (held_time[0] > it.now_ns) begin
			o.status       = dirq_pkg::STAT_NOT_DUE;
			o.release_time = held_time[0];
		end else begin
			o.status       = dirq_pkg::STAT_DISPATCHED;
			o.out_tag      = held_tag[0];
			o.release_time = held_time[0];
			for (int i = 1; i < held; i++) begin
				held_time[i-1] = held_time[i];
				held_tag[i-1]  = held_tag[i];
			end
			held--;
		end
		o.queue_count = held[6:0];
		return o;
	endfunction

	// response checker
	always @(posedge clk) begin
		dirq_pkg::rsp_t exp_rsp;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (pending_rsp.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected response %p", rsp);
			end else begin
				exp_rsp = pending_rsp.pop_front();
				if (rsp.status !== exp_rsp.status || rsp.out_tag !== exp_rsp.out_tag
						|| rsp.release_time !== exp_rsp.release_time
						|| rsp.queue_count !== exp_rsp.queue_count) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %p, got %p", exp_rsp, rsp);
				end
			end
		end
	end

	function automatic dirq_pkg::req_t mk(logic c, logic [63:0] now, logic [15:0] tag,
			logic rd, logic wr, logic dat, logic hd, logic [31:0] rw);
		dirq_pkg::req_t it;
		it.cmd         = c;
		it.now_ns      = now;
		it.req_tag     = tag;
		it.is_read     = rd;
		it.is_write    = wr;
		it.has_data    = dat;
		it.at_head     = hd;
		it.random_word = rw;
		return it;
	endfunction

	task automatic send(dirq_pkg::req_t it);
		if ($urandom_range(99) < send_idle) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		req       <= it;
		req_valid <= 1'b1;
		do @(posedge clk); while (!req_ready);
		pending_rsp.push_back(release_predict(it));
	endtask

	task automatic wait_idle();
		req_valid <= 1'b0;
		while (pending_rsp.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(logic [dirq_pkg::CFG_IDX_W-1:0] idx,
			logic [dirq_pkg::CFG_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_idx   <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (idx)
			dirq_pkg::CFG_RULE_ENABLE: cfg_en   = val[0];
			dirq_pkg::CFG_OP_FILTER:   cfg_filt = val[1:0];
			dirq_pkg::CFG_MEAN_DELAY:  cfg_mean = val[39:0];
			dirq_pkg::CFG_JITTER:      cfg_jit  = val[30:0];
			dirq_pkg::CFG_CORR_RHO:    cfg_rho  = val[31:0];
			default: ;
		endcase
	endtask

	task automatic set_rule(logic en, logic [1:0] filt, logic [39:0] mean, logic [30:0] jit,
			logic [31:0] rho);
		wait_idle();
		write_reg(dirq_pkg::CFG_RULE_ENABLE, {39'd0, en});
		write_reg(dirq_pkg::CFG_OP_FILTER, {38'd0, filt});
		write_reg(dirq_pkg::CFG_MEAN_DELAY, mean);
		write_reg(dirq_pkg::CFG_JITTER, {9'd0, jit});
		write_reg(dirq_pkg::CFG_CORR_RHO, {8'd0, rho});
	endtask

	task automatic flush_queue();
		int n;
		n = held;
		repeat (n) send(mk(dirq_pkg::CMD_DISPATCH, '1, '0, 0, 0, 0, 0, '0));
	endtask

	task automatic test_empty_and_extremes();
		send(mk(dirq_pkg::CMD_DISPATCH, '0, '1, 1, 1, 1, 1, '1));
		send(mk(dirq_pkg::CMD_INSERT, '1, 16'hFFFF, 1, 1, 1, 0, '1));
		send(mk(dirq_pkg::CMD_INSERT, 64'd5, 16'h0000, 0, 0, 0, 1, '0));
		send(mk(dirq_pkg::CMD_INSERT, 64'd0, 16'h1234, 1, 0, 1, 0, 32'h1));
		send(mk(dirq_pkg::CMD_DISPATCH, 64'd0, '0, 0, 0, 0, 0, '0));
		send(mk(dirq_pkg::CMD_DISPATCH, 64'd0, '0, 0, 0, 0, 0, '0));
		send(mk(dirq_pkg::CMD_DISPATCH, 64'hFFFF_FFFF_FFFF_FFFE, '0, 0, 0, 0, 0, '0));
		send(mk(dirq_pkg::CMD_DISPATCH, '1, '0, 0, 0, 0, 0, '0));
	endtask

	task automatic test_filters();
		for (int f = 0; f < 4; f++) begin
			set_rule(1'b1, f[1:0], 40'd100, 31'd0, 32'd0);
			for (int k = 0; k < 8; k++)
				send(mk(dirq_pkg::CMD_INSERT, 64'd1000, k[15:0], k[0], k[1], k[2], 0, '0));
			flush_queue();
		end
	endtask

	task automatic test_jitter_wrap();
		set_rule(1'b1, 2'd0, 40'd0, 31'd1000, 32'd0);
		send(mk(dirq_pkg::CMD_INSERT, 64'd10, 16'h00AA, 1, 0, 1, 0, 32'd3));
		send(mk(dirq_pkg::CMD_INSERT, 64'd0, 16'h00AB, 0, 1, 1, 1, 32'd1999));
		set_rule(1'b1, 2'd3, 40'hFF_FFFF_FFFF, 31'h7FFF_FFFF, 32'hFFFF_FFFF);
		send(mk(dirq_pkg::CMD_INSERT, 64'd0, 16'h00AC, 1, 1, 1, 1, '1));
		send(mk(dirq_pkg::CMD_INSERT, '1, 16'h00AD, 1, 1, 1, 0, 32'h8000_0000));
		flush_queue();
	endtask

	task automatic test_full();
		set_rule(1'b0, 2'd0, 40'd0, 31'd0, 32'd0);
		for (int k = 0; k < QDEPTH + 2; k++)
			send(mk(dirq_pkg::CMD_INSERT, 64'd7 * (k % 5), k[15:0], 1, 0, 1, 0, $urandom));
		flush_queue();
	endtask

	task automatic test_backpressure();
		set_rule(1'b1, 2'd0, 40'd50, 31'd20, 32'h4000_0000);
		stall_kick = ~stall_kick;
		for (int k = 0; k < 60; k++)
			send(mk(k % 8 == 7 ? dirq_pkg::CMD_DISPATCH : dirq_pkg::CMD_INSERT, 64'd100 + k,
				16'($urandom), 1, 1, 1, 0, $urandom));
		flush_queue();
	endtask

	task automatic test_random(int n);
		dirq_pkg::req_t it;
		for (int k = 0; k < n; k++) begin
			sim_now = sim_now + 64'($urandom_range(0, 600));
			it = mk(1'($urandom_range(1)), sim_now, 16'($urandom), 1'($urandom_range(1)),
				1'($urandom_range(1)), $urandom_range(3) != 0, $urandom_range(9) == 0,
				$urandom);
			if ($urandom_range(19) == 0)
				it.now_ns = {$urandom, $urandom};
			send(it);
		end
		flush_queue();
	endtask

	initial begin
		arst_n     = 1'b0;
		cfg_we     = 1'b0;
		cfg_idx    = '0;
		cfg_wdata  = '0;
		req_valid  = 1'b0;
		req        = '0;
		held       = 0;
		rand_hist  = '0;
		cfg_en     = 1'b0;
		cfg_filt   = '0;
		cfg_mean   = '0;
		cfg_jit    = '0;
		cfg_rho    = '0;
		mismatches = 0;
		cycles     = 0;
		send_idle  = 0;
		recv_idle  = 0;
		sim_now    = 64'd1000;
		stall_kick = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_and_extremes();
		test_filters();
		test_jitter_wrap();
		test_full();
		test_backpressure();

		send_idle = 11;
		recv_idle = 48;
		set_rule(1'b1, 2'd0, 40'd500, 31'd300, 32'd0);
		test_random(40);
		set_rule(1'b1, 2'd1, 40'hFF_FFFF_FFFF, 31'd0, 32'd0);
		test_random(25);
		send_idle = 48;
		recv_idle = 11;
		set_rule(1'b1, 2'd2, 40'd2000, 31'h7FFF_FFFF, 32'hFFFF_FFFF);
		test_random(40);
		set_rule(1'b1, 2'd3, 40'd1000, 31'd700, 32'h8000_0000);
		test_random(40);
		send_idle = 0;
		recv_idle = 0;
		set_rule(1'b0, 2'd0, 40'd300, 31'd1, 32'd1);
		test_random(25);

		wait_idle();
		repeat (30) @(posedge clk);
		if (mismatches == 0 && pending_rsp.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
